>>> rtl/pce_pkg.sv
// Shared types and constants for the palette classify/expand block.
// No dependencies; imported by pce_front, pce_cmd_fifo, pce_back.
package pce_pkg;

    localparam logic [2:0] FMT_MONO       = 3'd0;
    localparam logic [2:0] FMT_MONO_ALPHA = 3'd1;
    localparam logic [2:0] FMT_RGB        = 3'd2;
    localparam logic [2:0] FMT_RGBA       = 3'd3;
    localparam logic [2:0] FMT_ARGB       = 3'd4;

    localparam logic [7:0] BYTE_OPAQUE = 8'hFF;
    localparam logic [7:0] BYTE_CLEAR  = 8'h00;

    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        MASK_NONE = 2'd0,
        MASK_ONE  = 2'd1,
        MASK_OFF  = 2'd2
    } mask_state_t;

    // Classification snapshot carried with every request
    typedef struct packed {
        logic [2:0] format;
        logic       has_mask;
        logic [7:0] mask_gray;
        logic       is_identity;
        logic [8:0] loaded_count;
    } status_t;

    // One request from the front end to the back end
    typedef struct packed {
        logic        is_expand;
        logic        bad;
        logic        we;
        logic [7:0]  addr;
        logic [31:0] data;    // {alpha, red, green, blue}
        status_t     status;
    } cmd_t;

    function automatic logic [2:0] fmt_code(input logic color, input logic alpha,
                                            input logic order);
        logic [2:0] f;
        if (color)
            f = alpha ? (order ? FMT_RGBA : FMT_ARGB) : FMT_RGB;
        else
            f = alpha ? FMT_MONO_ALPHA : FMT_MONO;
        return f;
    endfunction

endpackage

>>> rtl/pce_front.sv
// Front end: accepts requests, keeps the running palette classification
// and builds one queue request per item. Depends on pce_pkg.
module pce_front #(
    parameter int PALETTE_DEPTH = 256
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_wr_en,
    input  logic           cfg_wr_data,
    input  logic           push,
    input  logic           op,
    input  logic           start_new,
    input  logic [7:0]     red,
    input  logic [7:0]     green,
    input  logic [7:0]     blue,
    input  logic [7:0]     alpha,
    input  logic [7:0]     pixel_index,
    input  logic           q_full,
    output logic           q_push,
    output pce_pkg::cmd_t  q_cmd
);
    import pce_pkg::*;

    localparam logic [8:0] DEPTH_C = 9'(PALETTE_DEPTH);

    logic [8:0]  count_reg;
    logic        identity_reg;
    logic        alpha_seen_reg;
    logic        color_seen_reg;
    mask_state_t mask_state_reg;
    logic [7:0]  mask_value_reg;
    logic        alpha_order_reg;

    logic [8:0]  count_next;
    logic        identity_next;
    logic        alpha_seen_next;
    logic        color_seen_next;
    mask_state_t mask_state_next;
    logic [7:0]  mask_value_next;

    logic        room;
    logic        accept;
    status_t     snap;

    assign accept = push && !q_full;
    assign q_push = accept;

    always_comb
    begin
        // cleared view first, then the entry update
        count_next      = start_new ? 9'd0 : count_reg;
        identity_next   = start_new ? 1'b1 : identity_reg;
        alpha_seen_next = start_new ? 1'b0 : alpha_seen_reg;
        color_seen_next = start_new ? 1'b0 : color_seen_reg;
        mask_state_next = start_new ? MASK_NONE : mask_state_reg;
        mask_value_next = start_new ? 8'd0 : mask_value_reg;
        room            = count_next < DEPTH_C;

        q_cmd.we   = room;
        q_cmd.addr = count_next[7:0];

        if (room)
        begin
            if ({1'b0, red} != count_next)
                identity_next = 1'b0;
            if (alpha != BYTE_OPAQUE)
                alpha_seen_next = 1'b1;
            if (red != green || green != blue)
            begin
                color_seen_next = 1'b1;
                if (alpha != BYTE_OPAQUE)
                    mask_state_next = MASK_OFF;
            end
            else if (alpha == BYTE_CLEAR)
            begin
                if (mask_state_next == MASK_NONE)
                begin
                    mask_state_next = MASK_ONE;
                    mask_value_next = red;
                end
                else if (mask_state_next == MASK_ONE && mask_value_next != red)
                    mask_state_next = MASK_OFF;
            end
            else if (alpha != BYTE_OPAQUE)
                mask_state_next = MASK_OFF;
            count_next = count_next + 9'd1;
        end

        q_cmd.is_expand = op;
        q_cmd.data      = {alpha, red, green, blue};
        if (op)
        begin
            // expand: classification unchanged
            q_cmd.bad  = {1'b0, pixel_index} >= count_reg;
            q_cmd.we   = 1'b0;
            q_cmd.addr = pixel_index;
            snap.format       = fmt_code(color_seen_reg, alpha_seen_reg, alpha_order_reg);
            snap.has_mask     = mask_state_reg == MASK_ONE;
            snap.mask_gray    = (mask_state_reg == MASK_ONE) ? mask_value_reg : 8'd0;
            snap.is_identity  = identity_reg;
            snap.loaded_count = count_reg;
        end
        else
        begin
            q_cmd.bad = 1'b0;
            snap.format       = fmt_code(color_seen_next, alpha_seen_next, alpha_order_reg);
            snap.has_mask     = mask_state_next == MASK_ONE;
            snap.mask_gray    = (mask_state_next == MASK_ONE) ? mask_value_next : 8'd0;
            snap.is_identity  = identity_next;
            snap.loaded_count = count_next;
        end
        q_cmd.status = snap;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg       <= 9'd0;
            identity_reg    <= 1'b1;
            alpha_seen_reg  <= 1'b0;
            color_seen_reg  <= 1'b0;
            mask_state_reg  <= MASK_NONE;
            mask_value_reg  <= 8'd0;
            alpha_order_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                alpha_order_reg <= cfg_wr_data;
            if (accept && !op)
            begin
                count_reg      <= count_next;
                identity_reg   <= identity_next;
                alpha_seen_reg <= alpha_seen_next;
                color_seen_reg <= color_seen_next;
                mask_state_reg <= mask_state_next;
                mask_value_reg <= mask_value_next;
            end
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("entry count above palette depth");

    a_load_counts: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !op && !start_new && count_reg < DEPTH_C
        |=> count_reg == $past(count_reg) + 9'd1)
        else $error("load with room did not advance entry count");

endmodule

>>> rtl/pce_cmd_fifo.sv
// Short request queue between front and back end.
// Depends on pce_pkg (cmd_t, QUEUE_DEPTH).
module pce_cmd_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  pce_pkg::cmd_t  wr_cmd,
    output logic           full,
    input  logic           rd_en,
    output pce_pkg::cmd_t  rd_cmd,
    output logic           empty
);
    import pce_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             slots [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] fill_reg;

    assign full   = fill_reg == CNT_W'(QUEUE_DEPTH);
    assign empty  = fill_reg == '0;
    assign rd_cmd = slots[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            slots[wr_ptr_reg] <= wr_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            if (rd_en)
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            if (wr_en && !rd_en)
                fill_reg <= fill_reg + CNT_W'(1);
            else if (rd_en && !wr_en)
                fill_reg <= fill_reg - CNT_W'(1);
        end
    end

endmodule

>>> rtl/pce_back.sv
// Back end: owns the palette memory, executes queued requests and streams
// result bytes through a one-entry output register. Depends on pce_pkg.
module pce_back #(
    parameter int PALETTE_DEPTH = 256
) (
    input  logic           clk,
    input  logic           rst_n,
    input  pce_pkg::cmd_t  q_cmd,
    input  logic           q_empty,
    output logic           q_pop,
    input  logic           pop,
    output logic           empty,
    output logic [7:0]     out_byte,
    output logic           last,
    output logic [2:0]     format,
    output logic           has_mask,
    output logic [7:0]     mask_gray,
    output logic           is_identity,
    output logic           bad_index,
    output logic [8:0]     loaded_count
);
    import pce_pkg::*;

    localparam int IDX_W = $clog2(PALETTE_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_REPLY = 3'b010,
        S_EMIT  = 3'b100
    } state_t;

    state_t      state_reg;
    cmd_t        cur_reg;
    logic [1:0]  k_reg;
    logic [31:0] rd_data_reg;
    logic [31:0] palette [PALETTE_DEPTH];

    logic        out_valid_reg;
    logic        out_valid_next;
    logic [7:0]  out_byte_reg;
    logic        last_reg;
    logic        bad_reg;
    status_t     status_reg;

    logic        out_free;
    logic        out_load;
    logic [2:0]  n_bytes;
    logic [7:0]  sel_byte;
    logic        sel_last;
    logic [7:0]  ea, er, eg, eb;

    assign out_free = !out_valid_reg || pop;
    assign out_load = out_free && (state_reg == S_REPLY || state_reg == S_EMIT);
    assign out_valid_next = out_load || (out_valid_reg && !pop);
    assign q_pop    = (state_reg == S_IDLE) && !q_empty;
    assign {ea, er, eg, eb} = rd_data_reg;

    always_comb
    begin
        case (cur_reg.status.format)
            FMT_MONO:       n_bytes = 3'd1;
            FMT_MONO_ALPHA: n_bytes = 3'd2;
            FMT_RGB:        n_bytes = 3'd3;
            default:        n_bytes = 3'd4;
        endcase
        case (cur_reg.status.format)
            FMT_MONO:
                sel_byte = er;
            FMT_MONO_ALPHA:
                if (k_reg == 2'd0)
                    sel_byte = er;
                else if (cur_reg.status.has_mask)
                    sel_byte = (er == cur_reg.status.mask_gray) ? BYTE_CLEAR : BYTE_OPAQUE;
                else
                    sel_byte = ea;
            FMT_RGB, FMT_RGBA:
                case (k_reg)
                    2'd0:    sel_byte = er;
                    2'd1:    sel_byte = eg;
                    2'd2:    sel_byte = eb;
                    default: sel_byte = ea;
                endcase
            default:
                case (k_reg)
                    2'd0:    sel_byte = ea;
                    2'd1:    sel_byte = er;
                    2'd2:    sel_byte = eg;
                    default: sel_byte = eb;
                endcase
        endcase
        if (cur_reg.bad)
            sel_byte = 8'd0;
        sel_last = {1'b0, k_reg} == n_bytes - 3'd1;
    end

    // palette store: written by loads in queue order, read registered
    always_ff @(posedge clk)
    begin
        if (q_pop && !q_cmd.is_expand && q_cmd.we)
            palette[q_cmd.addr[IDX_W-1:0]] <= q_cmd.data;
        if (q_pop && q_cmd.is_expand)
            rd_data_reg <= palette[q_cmd.addr[IDX_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            cur_reg <= q_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            k_reg         <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            unique case (state_reg)
                S_IDLE:
                    if (!q_empty)
                    begin
                        k_reg     <= 2'd0;
                        state_reg <= q_cmd.is_expand ? S_EMIT : S_REPLY;
                    end
                S_REPLY:
                    if (out_free)
                        state_reg <= S_IDLE;
                S_EMIT:
                    if (out_free)
                    begin
                        k_reg <= k_reg + 2'd1;
                        if (sel_last)
                            state_reg <= S_IDLE;
                    end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && state_reg == S_REPLY)
        begin
            out_byte_reg <= 8'd0;
            last_reg     <= 1'b1;
            bad_reg      <= 1'b0;
            status_reg   <= cur_reg.status;
        end
        else if (out_free && state_reg == S_EMIT)
        begin
            out_byte_reg <= sel_byte;
            last_reg     <= sel_last;
            bad_reg      <= cur_reg.bad;
            status_reg   <= cur_reg.status;
        end
    end

    assign empty        = !out_valid_reg;
    assign out_byte     = out_byte_reg;
    assign last         = last_reg;
    assign bad_index    = bad_reg;
    assign format       = status_reg.format;
    assign has_mask     = status_reg.has_mask;
    assign mask_gray    = status_reg.mask_gray;
    assign is_identity  = status_reg.is_identity;
    assign loaded_count = status_reg.loaded_count;

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && bad_reg |-> out_byte_reg == 8'd0)
        else $error("out-of-range pixel produced nonzero byte");

    a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EMIT |-> {1'b0, k_reg} < n_bytes)
        else $error("byte counter ran past format length");

endmodule

>>> rtl/palette_classify_expand_unit.sv
// Top level of the palette classify/expand block.
// Depends on pce_pkg, pce_front, pce_cmd_fifo and pce_back.

// Palette classify/expand unit. Items enter through a queue-style port
// (push/full) and results leave through one (empty/pop), one byte per
// result. A load item (op=0) stores one palette entry while there is room,
// updates the running classification and gives a single reply with out_byte
// 0 and last 1. An expand item (op=1) gives 1 to 4 bytes in memory order for
// the current format (mono, mono+alpha, RGB, RGBA or ARGB per alpha_order),
// last marking the final byte; an index at or above the loaded count gives
// zeros with bad_index set. The front end takes one item per cycle while the
// four-entry request queue is not full; the back end pops a request and, for
// a pixel, reads the palette memory into a register, then moves one byte per
// cycle into the output register while it is free. The palette memory has no
// reset and no clearing pass; only entries below the loaded count are ever
// used. The user must write alpha_order via cfg_wr_en/cfg_wr_data only while
// the unit is idle; the block itself does not enforce this.
module palette_classify_expand_unit #(
    parameter int PALETTE_DEPTH = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       push,
    output logic       full,
    input  logic       op,
    input  logic       start_new,
    input  logic [7:0] red,
    input  logic [7:0] green,
    input  logic [7:0] blue,
    input  logic [7:0] alpha,
    input  logic [7:0] pixel_index,
    input  logic       pop,
    output logic       empty,
    output logic [7:0] out_byte,
    output logic       last,
    output logic [2:0] format,
    output logic       has_mask,
    output logic [7:0] mask_gray,
    output logic       is_identity,
    output logic       bad_index,
    output logic [8:0] loaded_count
);
    import pce_pkg::*;

    // request path: front end -> queue -> back end
    cmd_t fe_cmd;
    cmd_t be_cmd;
    logic fe_push;
    logic q_full;
    logic q_empty;
    logic be_pop;

    assign full = q_full;

    pce_front #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .push        (push),
        .op          (op),
        .start_new   (start_new),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .alpha       (alpha),
        .pixel_index (pixel_index),
        .q_full      (q_full),
        .q_push      (fe_push),
        .q_cmd       (fe_cmd)
    );

    // decouples classification from the byte stream
    pce_cmd_fifo u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (fe_push),
        .wr_cmd (fe_cmd),
        .full   (q_full),
        .rd_en  (be_pop),
        .rd_cmd (be_cmd),
        .empty  (q_empty)
    );

    pce_back #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_cmd        (be_cmd),
        .q_empty      (q_empty),
        .q_pop        (be_pop),
        .pop          (pop),
        .empty        (empty),
        .out_byte     (out_byte),
        .last         (last),
        .format       (format),
        .has_mask     (has_mask),
        .mask_gray    (mask_gray),
        .is_identity  (is_identity),
        .bad_index    (bad_index),
        .loaded_count (loaded_count)
    );

endmodule

>>> tb/sv/palette_expand_checker.sv
// Checker for the palette classify/expand unit: watches the request, result and
// register ports, predicts every result byte and compares it field by field.
// Depends on pce_pkg for format codes, mask states and mask byte values.
`timescale 1ns / 1ps

module palette_expand_checker #(
    parameter int   DEPTH     = 256,
    parameter logic EXPAND_OP = 1'b1
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       push,
    input  logic       full,
    input  logic       op,
    input  logic       start_new,
    input  logic [7:0] red,
    input  logic [7:0] green,
    input  logic [7:0] blue,
    input  logic [7:0] alpha,
    input  logic [7:0] pixel_index,
    input  logic       pop,
    input  logic       empty,
    input  logic [7:0] out_byte,
    input  logic       last,
    input  logic [2:0] format,
    input  logic       has_mask,
    input  logic [7:0] mask_gray,
    input  logic       is_identity,
    input  logic       bad_index,
    input  logic [8:0] loaded_count,
    output int         mismatches,
    output int         pending,
    output int         checked
);
    import pce_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic [2:0] fmt;
        logic       masked;
        logic [7:0] gray;
        logic       ident;
        logic       bad;
        logic [8:0] count;
    } pixel_byte_t;

    pixel_byte_t bytes_owed[$];

    // own copy of the palette and its classification
    logic [31:0] entries [DEPTH];
    logic [8:0]  n_entries;
    logic        ident_all;
    logic        any_alpha;
    logic        any_color;
    mask_state_t mask_st;
    logic [7:0]  mask_val;
    logic        rgba_order;
    int          fail_count;
    int          seen_count;

    function automatic logic [2:0] palette_format();
        if (any_color)
            return any_alpha ? (rgba_order ? FMT_RGBA : FMT_ARGB) : FMT_RGB;
        return any_alpha ? FMT_MONO_ALPHA : FMT_MONO;
    endfunction

    function automatic pixel_byte_t stamp(input logic [7:0] d, input logic l, input logic b);
        pixel_byte_t t;
        t.data   = d;
        t.last   = l;
        t.fmt    = palette_format();
        t.masked = (mask_st == MASK_ONE);
        t.gray   = t.masked ? mask_val : 8'h00;
        t.ident  = ident_all;
        t.bad    = b;
        t.count  = n_entries;
        return t;
    endfunction

    task automatic clear_palette_class();
        n_entries = '0;
        ident_all = 1'b1;
        any_alpha = 1'b0;
        any_color = 1'b0;
        mask_st   = MASK_NONE;
        mask_val  = '0;
    endtask

    task automatic absorb_entry(input logic st, input logic [7:0] r, input logic [7:0] g,
                                input logic [7:0] b, input logic [7:0] a);
        if (st)
            clear_palette_class();
        // a full store drops the entry but still replies
        if (n_entries < DEPTH)
        begin
            entries[n_entries[7:0]] = {a, r, g, b};
            if ({1'b0, r} != n_entries)
                ident_all = 1'b0;
            if (a != BYTE_OPAQUE)
                any_alpha = 1'b1;
            if (r != g || g != b)
            begin
                any_color = 1'b1;
                if (a != BYTE_OPAQUE)
                    mask_st = MASK_OFF;
            end
            else if (a == BYTE_CLEAR)
            begin
                if (mask_st == MASK_NONE)
                begin
                    mask_st  = MASK_ONE;
                    mask_val = r;
                end
                else if (mask_st == MASK_ONE && mask_val != r)
                    mask_st = MASK_OFF;
            end
            else if (a != BYTE_OPAQUE)
                mask_st = MASK_OFF;
            n_entries++;
        end
        bytes_owed = {bytes_owed, stamp(8'h00, 1'b1, 1'b0)};
    endtask

    task automatic expand_index(input logic [7:0] idx);
        logic [2:0]  f;
        logic        b;
        logic [31:0] e;
        logic [7:0]  seq [4];
        int          n;
        f = palette_format();
        b = ({1'b0, idx} >= n_entries);
        e = b ? 32'h0 : entries[idx];
        case (f)
            FMT_MONO:
            begin
                seq[0] = e[23:16];
                n = 1;
            end
            FMT_MONO_ALPHA:
            begin
                seq[0] = e[23:16];
                if (mask_st == MASK_ONE)
                    seq[1] = (e[23:16] == mask_val) ? BYTE_CLEAR : BYTE_OPAQUE;
                else
                    seq[1] = e[31:24];
                n = 2;
            end
            FMT_RGB:
            begin
                seq[0] = e[23:16];
                seq[1] = e[15:8];
                seq[2] = e[7:0];
                n = 3;
            end
            FMT_RGBA:
            begin
                seq[0] = e[23:16];
                seq[1] = e[15:8];
                seq[2] = e[7:0];
                seq[3] = e[31:24];
                n = 4;
            end
            default:
            begin
                seq[0] = e[31:24];
                seq[1] = e[23:16];
                seq[2] = e[15:8];
                seq[3] = e[7:0];
                n = 4;
            end
        endcase
        for (int k = 0; k < n; k++)
            bytes_owed = {bytes_owed, stamp(b ? 8'h00 : seq[k], k == n - 1, b)};
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        fail_count++;
        if (fail_count <= 40)
            $display("[%0t] result %0d: %s got %0h want %0h", $realtime, seen_count, what,
                     got, want);
    endtask

    task automatic check_result();
        pixel_byte_t want;
        if (bytes_owed.size() == 0)
        begin
            report_mismatch("unexpected result byte", 32'(out_byte), 32'd0);
            return;
        end
        want = bytes_owed.pop_front();
        if (out_byte !== want.data)
            report_mismatch("out_byte", 32'(out_byte), 32'(want.data));
        if (last !== want.last)
            report_mismatch("last", 32'(last), 32'(want.last));
        if (format !== want.fmt)
            report_mismatch("format", 32'(format), 32'(want.fmt));
        if (has_mask !== want.masked)
            report_mismatch("has_mask", 32'(has_mask), 32'(want.masked));
        if (mask_gray !== want.gray)
            report_mismatch("mask_gray", 32'(mask_gray), 32'(want.gray));
        if (is_identity !== want.ident)
            report_mismatch("is_identity", 32'(is_identity), 32'(want.ident));
        if (bad_index !== want.bad)
            report_mismatch("bad_index", 32'(bad_index), 32'(want.bad));
        if (loaded_count !== want.count)
            report_mismatch("loaded_count", 32'(loaded_count), 32'(want.count));
        seen_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_palette_class();
            rgba_order = 1'b0;
            bytes_owed.delete();
            fail_count = 0;
            seen_count = 0;
        end
        else
        begin
            if (cfg_wr_en)
                rgba_order = cfg_wr_data;
            if (push && !full)
            begin
                if (op == EXPAND_OP)
                    expand_index(pixel_index);
                else
                    absorb_entry(start_new, red, green, blue, alpha);
            end
            if (pop && !empty)
                check_result();
        end
        mismatches <= fail_count;
        pending    <= bytes_owed.size();
        checked    <= seen_count;
    end

endmodule

>>> tb/sv/palette_classify_expand_unit_tb.sv
// Top of the palette classify/expand testbench: clock, reset, request and pop
// drivers, register writes and the verdict. Depends on pce_pkg,
// palette_classify_expand_unit and palette_expand_checker.
`timescale 1ns / 1ps

module palette_classify_expand_unit_tb;

    import pce_pkg::*;

    localparam logic OP_LOAD     = 1'b0;
    localparam logic OP_EXPAND   = 1'b1;
    localparam logic ORDER_ARGB  = 1'b0;
    localparam logic ORDER_RGBA  = 1'b1;

    localparam int RANDOM_ITEMS = 190;
    localparam int PHASE_ITEMS  = 28;
    localparam int LONG_STALL   = 80;      // receiver hold-off, well past queue depth
    localparam int SETTLE       = 12;      // lets the back end finish its last request
    localparam int CYCLE_LIMIT  = 400000;

    // idling modes: none, sender idle, receiver stalls, both lightly
    typedef enum int { IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH } idle_mode_t;

    // shapes of random palettes
    typedef enum int {
        PAL_IDENTITY, PAL_KEYED, PAL_GRAY_ALPHA, PAL_COLOR, PAL_COLOR_ALPHA, PAL_TWO_LEVEL
    } palette_kind_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_wr_en;
    logic       cfg_wr_data;
    logic       push;
    logic       full;
    logic       op;
    logic       start_new;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [7:0] pixel_index;
    logic       pop;
    logic       empty;
    logic [7:0] out_byte;
    logic       last;
    logic [2:0] format;
    logic       has_mask;
    logic [7:0] mask_gray;
    logic       is_identity;
    logic       bad_index;
    logic [8:0] loaded_count;

    int mismatches;
    int pending;
    int checked;

    int tx_idle_pct;
    int rx_stall_pct;
    int stall_req_id;
    int stall_ack_id;
    int stall_left;
    int cycle_count;
    int load_items;
    int pixel_items;
    int random_items;

    always #1 clk = ~clk;

    palette_classify_expand_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .push         (push),
        .full         (full),
        .op           (op),
        .start_new    (start_new),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .alpha        (alpha),
        .pixel_index  (pixel_index),
        .pop          (pop),
        .empty        (empty),
        .out_byte     (out_byte),
        .last         (last),
        .format       (format),
        .has_mask     (has_mask),
        .mask_gray    (mask_gray),
        .is_identity  (is_identity),
        .bad_index    (bad_index),
        .loaded_count (loaded_count)
    );

    palette_expand_checker #(.EXPAND_OP(OP_EXPAND)) u_checker (.*);

    // Result side: random pop stalls, plus a long hold-off whenever the
    // stimulus bumps stall_req_id.
    always @(posedge clk)
    begin
        if (stall_req_id != stall_ack_id)
        begin
            stall_ack_id = stall_req_id;
            stall_left   = LONG_STALL;
        end
        if (stall_left > 0)
        begin
            stall_left--;
            pop <= 1'b0;
        end
        else
            pop <= ($urandom_range(99) >= rx_stall_pct);
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d result bytes outstanding", cycle_count,
                     pending);
            $display("FAIL");
            $finish;
        end
    end

    // One request; returns at the edge where it was taken. Random idle
    // cycles go in front of it per the current sender mode.
    task automatic send_item(input logic o, input logic st, input logic [7:0] r,
                             input logic [7:0] g, input logic [7:0] b, input logic [7:0] a,
                             input logic [7:0] idx);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push        <= 1'b1;
        op          <= o;
        start_new   <= st;
        red         <= r;
        green       <= g;
        blue        <= b;
        alpha       <= a;
        pixel_index <= idx;
        // full read right after the edge is its value at that edge
        do
            @(posedge clk);
        while (full);
        if (o == OP_EXPAND)
            pixel_items++;
        else
            load_items++;
    endtask

    task automatic load(input logic st, input logic [7:0] r, input logic [7:0] g,
                        input logic [7:0] b, input logic [7:0] a);
        send_item(OP_LOAD, st, r, g, b, a, 8'($urandom_range(255)));
    endtask

    task automatic expand(input logic [7:0] idx);
        send_item(OP_EXPAND, 1'($urandom_range(1)), 8'($urandom_range(255)),
                  8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(255)), idx);
    endtask

    // Drain everything outstanding, then let the back end settle.
    task automatic wait_idle();
        push <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_alpha_order(input logic ord);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= ord;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic set_idling(input idle_mode_t m);
        case (m)
            IDLE_NONE:
            begin
                tx_idle_pct  <= 0;
                rx_stall_pct <= 0;
            end
            IDLE_SENDER:
            begin
                tx_idle_pct  <= 58;
                rx_stall_pct <= 0;
            end
            IDLE_RECEIVER:
            begin
                tx_idle_pct  <= 0;
                rx_stall_pct <= 58;
            end
            default:
            begin
                tx_idle_pct  <= 10;
                rx_stall_pct <= 10;
            end
        endcase
    endtask

    // A fresh palette of one shape, then pixels that mostly hit it.
    task automatic random_burst();
        palette_kind_t kind;
        int            n_load;
        int            n_pix;
        int            held;
        logic [7:0]    key;
        logic [7:0]    r;
        logic [7:0]    g;
        logic [7:0]    b;
        logic [7:0]    a;
        logic [7:0]    idx;
        logic          st;
        kind   = palette_kind_t'($urandom_range(5));
        n_load = ($urandom_range(7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
        n_pix  = $urandom_range(2, 10);
        key    = 8'($urandom_range(255));
        held   = 0;
        for (int k = 0; k < n_load; k++)
        begin
            // an occasional restart in the middle
            st = (k == 0) || ($urandom_range(24) == 0);
            if (st)
                held = 0;
            r = 8'($urandom_range(255));
            g = r;
            b = r;
            a = BYTE_OPAQUE;
            case (kind)
                PAL_IDENTITY:
                begin
                    r = 8'(held);
                    g = 8'(held);
                    b = 8'(held);
                end
                PAL_KEYED:
                    if ($urandom_range(3) == 0)
                    begin
                        r = key;
                        g = key;
                        b = key;
                        a = BYTE_CLEAR;
                    end
                PAL_GRAY_ALPHA:
                    a = 8'($urandom_range(255));
                PAL_COLOR:
                begin
                    g = 8'($urandom_range(255));
                    b = 8'($urandom_range(255));
                end
                PAL_COLOR_ALPHA:
                begin
                    g = 8'($urandom_range(255));
                    b = 8'($urandom_range(255));
                    a = 8'($urandom_range(255));
                end
                default:
                    a = $urandom_range(1) ? BYTE_CLEAR : BYTE_OPAQUE;
            endcase
            load(st, r, g, b, a);
            held++;
        end
        for (int k = 0; k < n_pix; k++)
        begin
            idx = (held == 0 || $urandom_range(5) == 0) ? 8'($urandom_range(255))
                                                        : 8'($urandom_range(held - 1));
            expand(idx);
        end
        random_items += n_load + n_pix;
        // some noise: fully random requests
        if ($urandom_range(9) == 0)
            repeat ($urandom_range(1, 4))
            begin
                send_item(1'($urandom_range(1)), 1'($urandom_range(1)),
                          8'($urandom_range(255)), 8'($urandom_range(255)),
                          8'($urandom_range(255)), 8'($urandom_range(255)),
                          8'($urandom_range(255)));
                random_items++;
            end
    endtask

    initial
    begin
        int phase_start;
        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = 1'b0;
        push         = 1'b0;
        op           = OP_LOAD;
        start_new    = 1'b0;
        red          = '0;
        green        = '0;
        blue         = '0;
        alpha        = '0;
        pixel_index  = '0;
        pop          = 1'b0;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        stall_req_id = 0;
        stall_ack_id = 0;
        stall_left   = 0;
        cycle_count  = 0;
        load_items   = 0;
        pixel_items  = 0;
        random_items = 0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // ---- directed part, alpha order at its reset value (ARGB) ----
        expand(8'h00);                                   // empty palette: bad index
        expand(8'hFF);
        load(1'b1, 8'h00, 8'h00, 8'h00, BYTE_OPAQUE);    // mono identity
        load(1'b0, 8'h01, 8'h01, 8'h01, BYTE_OPAQUE);
        expand(8'h00);
        expand(8'h01);
        expand(8'h02);                                   // one past the end
        load(1'b0, 8'h02, 8'h02, 8'h02, BYTE_CLEAR);     // single transparent gray
        expand(8'h02);
        expand(8'h01);
        load(1'b0, 8'h09, 8'h09, 8'h09, BYTE_CLEAR);     // second one kills the mask
        expand(8'h03);
        expand(8'h00);
        load(1'b1, 8'hFF, 8'hFF, 8'hFF, BYTE_OPAQUE);    // restart, not identity
        load(1'b0, 8'h10, 8'h20, 8'h30, BYTE_OPAQUE);    // RGB
        expand(8'h01);
        load(1'b0, 8'h80, 8'h40, 8'hC0, 8'h7F);          // color with alpha: ARGB
        expand(8'h02);
        expand(8'h07);                                   // bad, four zero bytes
        load(1'b1, 8'h33, 8'h33, 8'h33, 8'h80);          // gray, partial alpha
        expand(8'h00);
        wait_idle();
        set_alpha_order(ORDER_RGBA);
        load(1'b1, 8'hAA, 8'h55, 8'h01, 8'hFE);
        expand(8'h00);
        expand(8'h01);

        // ---- random phases ----
        for (int ph = 0; random_items < RANDOM_ITEMS; ph++)
        begin
            wait_idle();
            set_idling(idle_mode_t'(ph % 4));
            if (ph < 2)
                set_alpha_order(ph[0] ? ORDER_RGBA : ORDER_ARGB);
            else
                set_alpha_order(1'($urandom_range(1)));
            // the receiver goes quiet while requests keep coming
            if (ph == 1 || ph == 6)
                stall_req_id <= stall_req_id + 1;
            phase_start = random_items;
            while (random_items - phase_start < PHASE_ITEMS)
                random_burst();
        end

        wait_idle();
        $display("covered %0d loads and %0d pixels, %0d result bytes checked,",
                 load_items, pixel_items, checked);
        $display("both alpha orders, all formats, masks, bad indexes and a long pop stall");
        if (pending != 0)
            $display("%0d expected result bytes never arrived", pending);
        if (mismatches == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
